// ----- rtl/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and codes for the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int DEF_NUM_IDS   = 128;
    localparam int DEF_WORD_BITS = 32;

    // wide enough for any identifier up to the largest supported map
    localparam int TOKEN_ID_W = 12;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;
    localparam logic [1:0] ST_NOT_USED  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [6:0] release_id;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] granted_id;
    } rsp_item_t;

    // request travelling along the row of bitmap cells
    typedef struct packed {
        logic                  active;
        logic                  kind;
        logic                  found;
        logic [6:0]            rid;
        logic [TOKEN_ID_W-1:0] id;
    } scan_token_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_SCAN,
        CTRL_HOLD
    } ctrl_state_t;

endpackage

// ----- rtl/bia_cell.sv -----
// ----------------------------------------------------------------------------
// bia_cell
// One bitmap word: serves the passing request and hands it to the next cell.
// ----------------------------------------------------------------------------
module bia_cell
    import bia_pkg::*;
#(
    parameter int NUM_IDS   = DEF_NUM_IDS,
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int CELL_IDX  = 0,
    parameter int CUR_W     = $clog2(DEF_NUM_IDS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CUR_W-1:0]  cursor,
    input  scan_token_t       tok_in,
    output scan_token_t       tok_out
);

    localparam int BASE  = CELL_IDX * WORD_BITS;
    localparam int BIT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    scan_token_t          tok_reg;
    scan_token_t          tok_next;
    logic [WORD_BITS-1:0] free_hit;
    logic [WORD_BITS-1:0] rel_hit;
    logic                 pick_found;
    logic [BIT_W-1:0]     pick_idx;

    always_comb
    begin
        free_hit   = '0;
        rel_hit    = '0;
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_hit[b] = !word_reg[b] && (BASE + b < NUM_IDS) && (int'(cursor) <= BASE + b);
            rel_hit[b]  = word_reg[b] && (int'(tok_in.rid) == BASE + b);
        end
        // lowest free bit wins
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_hit[b])
            begin
                pick_found = 1'b1;
                pick_idx   = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        word_next = word_reg;
        tok_next  = tok_in;
        if (tok_in.active && !tok_in.found)
        begin
            if (tok_in.kind == KIND_ALLOC)
            begin
                if (pick_found)
                begin
                    word_next[pick_idx] = 1'b1;
                    tok_next.found      = 1'b1;
                    tok_next.id         = TOKEN_ID_W'(BASE) + TOKEN_ID_W'(pick_idx);
                end
            end
            else if (|rel_hit)
            begin
                word_next      = word_reg & ~rel_hit;
                tok_next.found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/bia_ctrl.sv -----
// ----------------------------------------------------------------------------
// bia_ctrl
// Request launch, search cursor and response register of the allocator.
// ----------------------------------------------------------------------------
module bia_ctrl
    import bia_pkg::*;
#(
    parameter int NUM_IDS = DEF_NUM_IDS,
    parameter int CUR_W   = $clog2(DEF_NUM_IDS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_item_t        req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_item_t        rsp,
    output scan_token_t      launch,
    input  scan_token_t      tail,
    output logic [CUR_W-1:0] cursor
);

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;
    rsp_item_t        rsp_reg;
    rsp_item_t        rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_item_t        hold_reg;
    rsp_item_t        hold_next;
    rsp_item_t        result;
    logic             rsp_free;

    assign req_ready = (state_reg == CTRL_IDLE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        launch        = '0;
        launch.active = req_valid && req_ready;
        launch.kind   = req.kind;
        launch.rid    = req.release_id;
    end

    always_comb
    begin
        result = '0;
        if (tail.kind == KIND_ALLOC)
        begin
            result.status = tail.found ? ST_ALLOCATED : ST_FULL;
            if (tail.found)
            begin
                result.granted_id = tail.id[6:0];
            end
        end
        else
        begin
            result.status = tail.found ? ST_RELEASED : ST_NOT_USED;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        hold_next      = hold_reg;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = CTRL_SCAN;
                end
            end
            CTRL_SCAN:
            begin
                if (tail.active)
                begin
                    if (tail.kind == KIND_ALLOC)
                    begin
                        cursor_next = tail.found ? CUR_W'(tail.id) + CUR_W'(1)
                                                 : CUR_W'(NUM_IDS);
                    end
                    else if (tail.found)
                    begin
                        cursor_next = '0;
                    end
                    if (rsp_free)
                    begin
                        rsp_next       = result;
                        rsp_valid_next = 1'b1;
                        state_next     = CTRL_IDLE;
                    end
                    else
                    begin
                        hold_next  = result;
                        state_next = CTRL_HOLD;
                    end
                end
            end
            CTRL_HOLD:
            begin
                if (rsp_ready)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cursor    = cursor_reg;

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> state_reg == CTRL_SCAN)
        else $error("request left the cell row outside a scan");

    a_hold_has_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CTRL_HOLD |-> rsp_valid_reg)
        else $error("holding a result with the response register empty");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cursor_reg) <= NUM_IDS)
        else $error("search cursor beyond the map");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != ST_ALLOCATED) |-> rsp_reg.granted_id == '0)
        else $error("identifier returned without a grant");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg == CTRL_SCAN)
        else $error("accepted request did not start a scan");

endmodule

// ----- rtl/bitmap_id_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_id_allocator_top
// Identifier allocator: a row of bitmap word cells walked by each request.
// ----------------------------------------------------------------------------
// Usage
// - req channel (req_valid/req_ready/req): kind selects allocate or release,
//   release_id names the identifier to free; one request is in flight at a time
// - rsp channel (rsp_valid/rsp_ready/rsp): one response per request with the
//   status and, on a grant, the identifier
// - a request enters the first cell in the cycle of its transfer and moves one
//   word cell per cycle, so every request takes NUM_IDS/WORD_BITS cells
//   (rounded up) to cross the row; the controller then registers the response
// - the next request is taken only after that result is registered or parked, so
//   a new request is never taken before the last one has left the row
// - the length of the cell row sets the spacing between requests
// - reset clears every bitmap word (all identifiers free) and the cursor
// - while a response waits on a stalled receiver a new request is still taken;
//   its result is parked in the controller until the response register frees,
//   and no further request is taken until then
// ----------------------------------------------------------------------------
module bitmap_id_allocator_top
    import bia_pkg::*;
#(
    parameter int NUM_IDS   = DEF_NUM_IDS,
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int CUR_W     = $clog2(NUM_IDS + 1);

    scan_token_t      chain [MAP_WORDS+1];
    logic [CUR_W-1:0] cursor;

    bia_ctrl #(
        .NUM_IDS (NUM_IDS),
        .CUR_W   (CUR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .launch    (chain[0]),
        .tail      (chain[MAP_WORDS]),
        .cursor    (cursor)
    );

    for (genvar i = 0; i < MAP_WORDS; i++)
    begin : g_cell
        bia_cell #(
            .NUM_IDS   (NUM_IDS),
            .WORD_BITS (WORD_BITS),
            .CELL_IDX  (i),
            .CUR_W     (CUR_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cursor  (cursor),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

endmodule
